// ===== sv/cfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int MEM_UNITS_DEF  = 1024;
  localparam int OWNER_BITS_DEF = 8;

  localparam int OWNER_IN_W = 8;
  localparam int SIZE_W     = 11;
  localparam int BASE_W     = 10;
  localparam int START_W    = 10;
  localparam int POLICY_W   = 2;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  // code three behaves as first fit
  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_PLACE,
    S_WRITE,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic finish;
    logic place;
    logic write_step;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic write_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/cfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer: clearing pass, map scan, hole placement, run write, response.
// ----------------------------------------------------------------------------
module cfa_ctrl
  import cfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       action,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd,
  output logic       in_stall
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.write_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = (action == ACT_RELEASE) ? S_PLACE : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_FINISH;
      end
      S_FINISH: state_next = S_PLACE;
      S_PLACE:  state_next = S_WRITE;
      S_WRITE: begin
        if (stat.write_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_CLEAR: cmd.write_step = 1'b1;
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      S_SCAN:   cmd.scan_step  = 1'b1;
      S_FINISH: cmd.finish     = 1'b1;
      S_PLACE:  cmd.place      = 1'b1;
      S_WRITE:  cmd.write_step = 1'b1;
      S_RESP:   cmd.respond    = stat.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/cfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_datapath
// Owner map memory, hole tracker and chooser, run write engine, output item.
// ----------------------------------------------------------------------------
module cfa_datapath
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS  = MEM_UNITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic [POLICY_W-1:0]   policy,
  input  logic                  action,
  input  logic [OWNER_IN_W-1:0] owner,
  input  logic [SIZE_W-1:0]     size,
  input  logic [BASE_W-1:0]     base,
  input  logic                  out_stall,
  output dp_stat_t              stat,
  output logic                  out_valid,
  output logic                  status,
  output logic [START_W-1:0]    start_res
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int LW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
  localparam int EW = LW + 1;
  localparam int OW = (OWNER_BITS > OWNER_IN_W) ? OWNER_BITS : OWNER_IN_W;
  localparam int SW = (AW > START_W) ? AW : START_W;
  localparam logic [AW:0] MEM_CNT = (AW + 1)'(MEM_UNITS);

  logic [OWNER_BITS-1:0] mem [MEM_UNITS];

  logic                  action_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [SIZE_W-1:0]     size_q;
  logic [BASE_W-1:0]     base_q;

  logic [AW:0]           rd_cnt;
  logic                  dat_valid;
  logic [AW-1:0]         dat_idx;
  logic [OWNER_BITS-1:0] rd_data;

  logic [AW-1:0]         run_start;
  logic [AW:0]           run_len;
  logic                  found;
  logic [AW-1:0]         best_start;
  logic [AW:0]           best_len;

  logic [AW-1:0]         wr_addr;
  logic [AW:0]           wr_left;
  logic [OWNER_BITS-1:0] wdata;

  logic                  res_status;
  logic [START_W-1:0]    res_start;

  logic [OW-1:0]         owner_w;
  logic [LW-1:0]         run_len_l, size_l;
  logic                  dat_empty, cand_ok, better, take, issue;
  logic [EW-1:0]         base_e, size_e, end_e, end_sat, rel_len, mem_e;
  logic                  rel_ok;
  logic [SW-1:0]         best_w;

  assign owner_w   = OW'(owner);
  assign run_len_l = LW'(run_len);
  assign size_l    = LW'(size_q);
  assign dat_empty = (rd_data == '0);
  assign issue     = cmd.scan_step && (rd_cnt != MEM_CNT);

  // a hole is offered when an occupied unit ends it, or at the end of the scan
  assign cand_ok = (size_q != '0) && (run_len != '0) && (run_len_l >= size_l);
  assign better  = !found
                || ((policy == POL_BEST)  && (run_len < best_len))
                || ((policy == POL_WORST) && (run_len > best_len));
  assign take    = cand_ok && better && (cmd.finish || (dat_valid && !dat_empty));

  assign mem_e   = EW'(MEM_UNITS);
  assign base_e  = EW'(base_q);
  assign size_e  = EW'(size_q);
  assign end_e   = base_e + size_e;
  assign end_sat = (end_e > mem_e) ? mem_e : end_e;
  assign rel_len = end_sat - base_e;
  assign rel_ok  = (size_q != '0) && (base_e < mem_e);
  assign best_w  = SW'(best_start);

  always_ff @(posedge clk) begin
    if (cmd.write_step && (wr_left != '0)) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_q <= action;
      owner_q  <= owner_w[OWNER_BITS-1:0];
      size_q   <= size;
      base_q   <= base;
    end
  end

  // scan: one read issued per cycle, data follows in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      dat_valid <= 1'b0;
      run_len   <= '0;
      found     <= 1'b0;
    end else if (cmd.start) begin
      rd_cnt    <= '0;
      dat_valid <= 1'b0;
      run_len   <= '0;
      found     <= 1'b0;
    end else begin
      dat_valid <= issue;
      if (issue) begin
        rd_cnt  <= rd_cnt + 1'b1;
        dat_idx <= rd_cnt[AW-1:0];
      end
      if (dat_valid) begin
        if (dat_empty) begin
          if (run_len == '0) run_start <= dat_idx;
          run_len <= run_len + 1'b1;
        end else begin
          run_len <= '0;
        end
      end
      if (take) begin
        found      <= 1'b1;
        best_start <= run_start;
        best_len   <= run_len;
      end
    end
  end

  // run write engine; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_addr <= '0;
      wr_left <= MEM_CNT;
      wdata   <= '0;
    end else if (cmd.place) begin
      if (action_q == ACT_RELEASE) begin
        wr_addr    <= base_e[AW-1:0];
        wr_left    <= rel_ok ? rel_len[AW:0] : '0;
        wdata      <= '0;
        res_status <= ST_DONE;
        res_start  <= '0;
      end else if (found) begin
        wr_addr    <= best_start;
        wr_left    <= size_l[AW:0];
        wdata      <= owner_q;
        res_status <= ST_DONE;
        res_start  <= best_w[START_W-1:0];
      end else begin
        wr_left    <= '0;
        res_status <= ST_NOFIT;
        res_start  <= '0;
      end
    end else if (cmd.write_step && (wr_left != '0)) begin
      wr_addr <= wr_addr + 1'b1;
      wr_left <= wr_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status    <= res_status;
      start_res <= res_start;
    end
  end

  assign stat.scan_done  = (rd_cnt == MEM_CNT) && !dat_valid;
  assign stat.write_done = (wr_left == '0);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ===== sv/contiguous_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Owner map allocator with first, best and worst fit hole choice.
// ----------------------------------------------------------------------------
// Allocate: result time is set by the one-unit-per-cycle map scan and the one-unit-per-cycle
//   run write (no write on no fit).
// Release: clears its units, with no scan. One item in flight; the next is accepted from the
//   cycle in which the result appears, which may wait in the output register meanwhile.
// Reset: a clearing pass empties the map; items are held off meanwhile, policy writes are
//   taken at any time. Policy resets to first.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS  = MEM_UNITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [POLICY_W-1:0]   fit_policy,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [OWNER_IN_W-1:0] owner,
  input  logic [SIZE_W-1:0]     size,
  input  logic [BASE_W-1:0]     base,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic [START_W-1:0]    start_res
);

  logic [POLICY_W-1:0] policy;
  ctrl_cmd_t           cmd;
  dp_stat_t            stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      policy <= fit_policy;
    end
  end

  cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cfa_datapath #(
    .MEM_UNITS  (MEM_UNITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .policy    (policy),
    .action    (action),
    .owner     (owner),
    .size      (size),
    .base      (base),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .status    (status),
    .start_res (start_res)
  );

`ifndef NO_ASSERTIONS
  // the clearing pass holds off items straight after reset
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("item taken during clearing pass");

  // one item at a time: an accepted item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  // a result is raised only by a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while idle");
`endif

endmodule
